// File: src/seem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seem_pkg
// Shared types, widths, register indexes and helper functions for the
// safety event edge monitor.
// ----------------------------------------------------------------------------
package seem_pkg;

    // field widths
    localparam int unsigned STATUS_W   = 6;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned VEL_W      = 16;
    localparam int unsigned MASK_W     = 9;
    localparam int unsigned LIMIT_W    = 16;
    localparam int unsigned MAG_W      = VEL_W + 1;
    localparam int unsigned SQ_W       = 2 * VEL_W - 1;
    localparam int unsigned SUM_W      = 2 * VEL_W;
    localparam int unsigned LIMIT_SQ_W = 2 * LIMIT_W;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned BOUNDS_W   = 2 * POS_W;

    // register defaults
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 16'hFFFF;
    localparam logic [LIMIT_SQ_W-1:0] LIMIT_SQ_RESET = 32'hFFFE_0001;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FENCE_X   = 8'd0,
        REG_FENCE_Y   = 8'd1,
        REG_FENCE_Z   = 8'd2,
        REG_SPEED_XY  = 8'd3,
        REG_SPEED_Z   = 8'd4,
        REG_ACCEL_XY  = 8'd5,
        REG_ACCEL_Z   = 8'd6,
        REG_ATT_MODE  = 8'd7
    } t_reg_idx;

    // status flag bit positions
    localparam int unsigned ST_EST_ACTIVE = 0;
    localparam int unsigned ST_STA_ACTIVE = 1;
    localparam int unsigned ST_BAT_ACTIVE = 2;
    localparam int unsigned ST_EST_NEW    = 3;
    localparam int unsigned ST_EST_USABLE = 4;
    localparam int unsigned ST_IMU_NEW    = 5;

    // event mask bit positions
    localparam int unsigned EV_EST_LOST  = 0;
    localparam int unsigned EV_STA_LOST  = 1;
    localparam int unsigned EV_BAT_LOST  = 2;
    localparam int unsigned EV_UNUSABLE  = 3;
    localparam int unsigned EV_GEOFENCE  = 4;
    localparam int unsigned EV_SPEED_XY  = 5;
    localparam int unsigned EV_SPEED_Z   = 6;
    localparam int unsigned EV_ACCEL_XY  = 7;
    localparam int unsigned EV_ACCEL_Z   = 8;

    // one input tick
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic signed [VEL_W-1:0] acc_x;
        logic signed [VEL_W-1:0] acc_y;
        logic signed [VEL_W-1:0] acc_z;
    } t_item;

    // live configuration, horizontal limits kept squared
    typedef struct packed {
        logic [BOUNDS_W-1:0]   fence_x;
        logic [BOUNDS_W-1:0]   fence_y;
        logic [BOUNDS_W-1:0]   fence_z;
        logic [LIMIT_SQ_W-1:0] speed_xy_sq;
        logic [LIMIT_W-1:0]    speed_z;
        logic [LIMIT_SQ_W-1:0] accel_xy_sq;
        logic [LIMIT_W-1:0]    accel_z;
        logic                  att_mode;
    } t_cfg;

    // measurement stage result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                fence;
        logic                vz_over;
        logic                az_over;
        logic [SQ_W-1:0]     sq_vx;
        logic [SQ_W-1:0]     sq_vy;
        logic [SQ_W-1:0]     sq_ax;
        logic [SQ_W-1:0]     sq_ay;
    } t_meas;

    // position outside one fence axis, inverted bounds always violate
    function automatic logic outside(input logic signed [POS_W-1:0] p,
                                     input logic [BOUNDS_W-1:0] b);
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
        lo = signed'(b[POS_W-1:0]);
        hi = signed'(b[BOUNDS_W-1:POS_W]);
        return (p < lo) || (p > hi);
    endfunction

    // magnitude of a signed Q8.8 value, one bit wider
    function automatic logic [MAG_W-1:0] magnitude(input logic signed [VEL_W-1:0] v);
        logic signed [MAG_W-1:0] ext;
        ext = {v[VEL_W-1], v};
        return ext[MAG_W-1] ? unsigned'(-ext) : unsigned'(ext);
    endfunction

    // square of a signed Q8.8 value, never above 2^30
    function automatic logic [SQ_W-1:0] square(input logic signed [VEL_W-1:0] v);
        logic signed [SUM_W-1:0] p;
        p = v * v;
        return p[SQ_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: src/seem_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seem_in_if
// Input tick channel: valid/ready handshake with sensor payload.
// ----------------------------------------------------------------------------
interface seem_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  status_flags;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [15:0] cmd_acc_x;
    logic signed [15:0] cmd_acc_y;
    logic signed [15:0] cmd_acc_z;

    modport source (
        output valid, status_flags, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               cmd_acc_x, cmd_acc_y, cmd_acc_z,
        input  ready
    );
    modport sink (
        input  valid, status_flags, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               cmd_acc_x, cmd_acc_y, cmd_acc_z,
        output ready
    );
endinterface
`default_nettype wire

// File: src/seem_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seem_out_if
// Result channel: valid/ready handshake carrying the event mask.
// ----------------------------------------------------------------------------
interface seem_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] event_mask;

    modport source (output valid, event_mask, input ready);
    modport sink (input valid, event_mask, output ready);
endinterface
`default_nettype wire

// File: src/seem_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seem_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface seem_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/seem_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seem_cfg_regs
// Configuration register file. Horizontal limits are squared on write.
// ----------------------------------------------------------------------------
module seem_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    seem_cfg_if.sink          i_cfg,
    output seem_pkg::t_cfg    o_cfg
);

    seem_pkg::t_cfg                        r_cfg;
    seem_pkg::t_cfg                        n_cfg;
    logic [seem_pkg::LIMIT_W-1:0]          w_lim;
    logic [seem_pkg::LIMIT_SQ_W-1:0]       w_lim_sq;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // square of the written limit
    assign w_lim    = i_cfg.data[seem_pkg::LIMIT_W-1:0];
    assign w_lim_sq = w_lim * w_lim;

    // register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                seem_pkg::REG_FENCE_X:  n_cfg.fence_x     = i_cfg.data;
                seem_pkg::REG_FENCE_Y:  n_cfg.fence_y     = i_cfg.data;
                seem_pkg::REG_FENCE_Z:  n_cfg.fence_z     = i_cfg.data;
                seem_pkg::REG_SPEED_XY: n_cfg.speed_xy_sq = w_lim_sq;
                seem_pkg::REG_SPEED_Z:  n_cfg.speed_z     = w_lim;
                seem_pkg::REG_ACCEL_XY: n_cfg.accel_xy_sq = w_lim_sq;
                seem_pkg::REG_ACCEL_Z:  n_cfg.accel_z     = w_lim;
                seem_pkg::REG_ATT_MODE: n_cfg.att_mode    = i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fence_x     <= '0;
            r_cfg.fence_y     <= '0;
            r_cfg.fence_z     <= '0;
            r_cfg.speed_xy_sq <= seem_pkg::LIMIT_SQ_RESET;
            r_cfg.speed_z     <= seem_pkg::LIMIT_RESET;
            r_cfg.accel_xy_sq <= seem_pkg::LIMIT_SQ_RESET;
            r_cfg.accel_z     <= seem_pkg::LIMIT_RESET;
            r_cfg.att_mode    <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: src/seem_measure.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seem_measure
// Measurement logic: fence and vertical checks, horizontal squares.
// ----------------------------------------------------------------------------
module seem_measure (
    input  wire seem_pkg::t_cfg   i_cfg,
    input  wire seem_pkg::t_item  i_item,
    output seem_pkg::t_meas       o_meas
);

    // per-tick measurements
    always_comb begin
        o_meas.status  = i_item.status;
        o_meas.fence   = seem_pkg::outside(i_item.pos_x, i_cfg.fence_x)
                      || seem_pkg::outside(i_item.pos_y, i_cfg.fence_y)
                      || seem_pkg::outside(i_item.pos_z, i_cfg.fence_z);
        o_meas.vz_over = seem_pkg::magnitude(i_item.vel_z) > {1'b0, i_cfg.speed_z};
        o_meas.az_over = seem_pkg::magnitude(i_item.acc_z) > {1'b0, i_cfg.accel_z};
        o_meas.sq_vx   = seem_pkg::square(i_item.vel_x);
        o_meas.sq_vy   = seem_pkg::square(i_item.vel_y);
        o_meas.sq_ax   = seem_pkg::square(i_item.acc_x);
        o_meas.sq_ay   = seem_pkg::square(i_item.acc_y);
    end

endmodule
`default_nettype wire

// File: src/seem_events.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seem_events
// Condition flags, rising-edge event detection and the result register.
// ----------------------------------------------------------------------------
module seem_events (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire seem_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    input  wire seem_pkg::t_meas i_meas,
    output logic                 o_ready,
    seem_out_if.source           o_out
);

    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [seem_pkg::MASK_W-1:0]      r_mask;
    logic [seem_pkg::MASK_W-1:0]      n_mask;

    // condition flags
    logic r_prev_est, r_prev_sta, r_prev_bat, r_unusable, r_geofence;
    logic r_speed_xy, r_speed_z, r_accel_xy, r_accel_z;
    logic n_prev_est, n_prev_sta, n_prev_bat, n_unusable, n_geofence;
    logic n_speed_xy, n_speed_z, n_accel_xy, n_accel_z;

    logic [seem_pkg::SUM_W-1:0]       w_sum_v;
    logic [seem_pkg::SUM_W-1:0]       w_sum_a;
    logic                             w_vxy_over;
    logic                             w_axy_over;
    logic                             w_take;
    logic [seem_pkg::STATUS_W-1:0]    w_st;
    logic                             w_unus;
    logic [seem_pkg::MASK_W-1:0]      w_ev;

    // result register frees when empty or taken
    assign o_ready = !r_out_valid || o_out.ready;
    assign w_take  = i_valid && o_ready;

    // horizontal squared magnitudes against squared limits
    assign w_sum_v    = {1'b0, i_meas.sq_vx} + {1'b0, i_meas.sq_vy};
    assign w_sum_a    = {1'b0, i_meas.sq_ax} + {1'b0, i_meas.sq_ay};
    assign w_vxy_over = w_sum_v > i_cfg.speed_xy_sq;
    assign w_axy_over = w_sum_a > i_cfg.accel_xy_sq;
    assign w_st       = i_meas.status;
    assign w_unus     = w_st[seem_pkg::ST_EST_ACTIVE] && !w_st[seem_pkg::ST_EST_USABLE];

    // flag update and event mask
    always_comb begin
        n_prev_est = r_prev_est;
        n_prev_sta = r_prev_sta;
        n_prev_bat = r_prev_bat;
        n_unusable = r_unusable;
        n_geofence = r_geofence;
        n_speed_xy = r_speed_xy;
        n_speed_z  = r_speed_z;
        n_accel_xy = r_accel_xy;
        n_accel_z  = r_accel_z;
        w_ev       = '0;

        // sensor loss on falling active bits, unusable estimate on its rising edge
        w_ev[seem_pkg::EV_EST_LOST] = r_prev_est && !w_st[seem_pkg::ST_EST_ACTIVE];
        w_ev[seem_pkg::EV_STA_LOST] = r_prev_sta && !w_st[seem_pkg::ST_STA_ACTIVE];
        w_ev[seem_pkg::EV_BAT_LOST] = r_prev_bat && !w_st[seem_pkg::ST_BAT_ACTIVE];
        w_ev[seem_pkg::EV_UNUSABLE] = !r_unusable && w_unus;
        n_prev_est = w_st[seem_pkg::ST_EST_ACTIVE];
        n_prev_sta = w_st[seem_pkg::ST_STA_ACTIVE];
        n_prev_bat = w_st[seem_pkg::ST_BAT_ACTIVE];
        n_unusable = w_unus;

        // estimate checks only on a fresh estimate
        if (w_st[seem_pkg::ST_EST_NEW]) begin
            w_ev[seem_pkg::EV_GEOFENCE] = !r_geofence && i_meas.fence;
            w_ev[seem_pkg::EV_SPEED_XY] = !r_speed_xy && w_vxy_over;
            w_ev[seem_pkg::EV_SPEED_Z]  = !r_speed_z && i_meas.vz_over;
            n_geofence = i_meas.fence;
            n_speed_xy = w_vxy_over;
            n_speed_z  = i_meas.vz_over;
        end

        // saturation checks, cleared in attitude-rate mode
        if (i_cfg.att_mode) begin
            n_accel_xy = 1'b0;
            n_accel_z  = 1'b0;
        end else if (w_st[seem_pkg::ST_IMU_NEW]) begin
            w_ev[seem_pkg::EV_ACCEL_XY] = !r_accel_xy && w_axy_over;
            w_ev[seem_pkg::EV_ACCEL_Z]  = !r_accel_z && i_meas.az_over;
            n_accel_xy = w_axy_over;
            n_accel_z  = i_meas.az_over;
        end
    end

    // output register load
    always_comb begin
        n_out_valid = r_out_valid;
        n_mask      = r_mask;
        if (o_ready) begin
            n_out_valid = i_valid;
            n_mask      = w_ev;
        end
    end

    // control and flag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_est  <= 1'b0;
            r_prev_sta  <= 1'b0;
            r_prev_bat  <= 1'b0;
            r_unusable  <= 1'b0;
            r_geofence  <= 1'b0;
            r_speed_xy  <= 1'b0;
            r_speed_z   <= 1'b0;
            r_accel_xy  <= 1'b0;
            r_accel_z   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_prev_est <= n_prev_est;
                r_prev_sta <= n_prev_sta;
                r_prev_bat <= n_prev_bat;
                r_unusable <= n_unusable;
                r_geofence <= n_geofence;
                r_speed_xy <= n_speed_xy;
                r_speed_z  <= n_speed_z;
                r_accel_xy <= n_accel_xy;
                r_accel_z  <= n_accel_z;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_mask = r_mask;

endmodule
`default_nettype wire

// File: src/safety_event_edge_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// safety_event_edge_monitor
// Edge-triggered safety event detection over sensor status, position,
// velocity and commanded acceleration ticks.
// ----------------------------------------------------------------------------
// path: the input register, then checks and flags into the result register
// throughput: one tick per cycle; the input register holds under output
//   backpressure and frees as soon as the result register moves
// reset: synchronous active low; clears pipeline valids and all condition
//   flags, fence bounds to zero, limits to 0xFFFF, attitude-rate mode off
module safety_event_edge_monitor (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    seem_cfg_if.sink     i_cfg,
    seem_in_if.sink      i_in,
    seem_out_if.source   o_out
);

    seem_pkg::t_cfg   w_cfg;
    seem_pkg::t_item  w_in_item;
    seem_pkg::t_item  r_s1_item;
    seem_pkg::t_item  n_s1_item;
    logic             r_s1_valid;
    logic             n_s1_valid;
    logic             w_s1_ready;
    logic             w_s3_ready;
    seem_pkg::t_meas  w_meas;

    // configuration registers
    seem_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // gather the input payload
    always_comb begin
        w_in_item.status = i_in.status_flags;
        w_in_item.pos_x  = i_in.pos_x;
        w_in_item.pos_y  = i_in.pos_y;
        w_in_item.pos_z  = i_in.pos_z;
        w_in_item.vel_x  = i_in.vel_x;
        w_in_item.vel_y  = i_in.vel_y;
        w_in_item.vel_z  = i_in.vel_z;
        w_in_item.acc_x  = i_in.cmd_acc_x;
        w_in_item.acc_y  = i_in.cmd_acc_y;
        w_in_item.acc_z  = i_in.cmd_acc_z;
    end

    // input register
    assign w_s1_ready = !r_s1_valid || w_s3_ready;
    assign i_in.ready = w_s1_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_item  = r_s1_item;
        if (w_s1_ready) begin
            n_s1_valid = i_in.valid;
            n_s1_item  = w_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= n_s1_item;
    end

    // fence, vertical and squared horizontal measurements
    seem_measure u_measure (
        .i_cfg   (w_cfg),
        .i_item  (r_s1_item),
        .o_meas  (w_meas)
    );

    // flags, events and result register
    seem_events u_events (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (r_s1_valid),
        .i_meas  (w_meas),
        .o_ready (w_s3_ready),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
